>>> rtl/core/gng_pkg.sv
// Package for the grid neighbour generator.
// Holds the request codes, register indexes, state encoding and default sizes.
// No dependencies.
package gng_pkg;

  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 64;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_DIAG = 2'd2;

  localparam logic [6:0] ROWS_RST = 7'd64;
  localparam logic [6:0] COLS_RST = 7'd64;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_QUERY = 2'd2
  } gng_func_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_MOD,
    ST_Q_UP,
    ST_Q_MID,
    ST_Q_DN,
    ST_Q_CAP,
    ST_EMIT,
    ST_EMPTY
  } gng_state_e;

  // Neighbour slots, in emission order.
  localparam logic [2:0] NB_UP = 3'd0;
  localparam logic [2:0] NB_DN = 3'd1;
  localparam logic [2:0] NB_LF = 3'd2;
  localparam logic [2:0] NB_RT = 3'd3;
  localparam logic [2:0] NB_UL = 3'd4;
  localparam logic [2:0] NB_UR = 3'd5;
  localparam logic [2:0] NB_DL = 3'd6;
  localparam logic [2:0] NB_DR = 3'd7;

endpackage

>>> rtl/core/gng_if.sv
// Request and result channel interfaces of the grid neighbour generator.
// Each carries valid, ready and the payload fields. No dependencies.
interface gng_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic       is_barrier;

  modport source (output valid, func, cell_row, cell_col, is_barrier, input ready);
  modport sink (input valid, func, cell_row, cell_col, is_barrier, output ready);
endinterface

interface gng_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] nbr_row;
  logic [5:0] nbr_col;
  logic       is_diagonal;
  logic       found;
  logic       last;

  modport source (output valid, nbr_row, nbr_col, is_diagonal, found, last, input ready);
  modport sink (input valid, nbr_row, nbr_col, is_diagonal, found, last, output ready);
endinterface

>>> rtl/core/grid_neighbour_generator.sv
// Top level of the grid neighbour generator: barrier map in a RAM, APB registers,
// request sequencer and result register. Depends on gng_pkg, gng_if and gng_ram.
//
//   channel  | direction | handshake     | payload
//   req_i    | in        | valid/ready   | func, cell_row, cell_col, is_barrier
//   rsp_o    | out       | valid/ready   | nbr_row, nbr_col, is_diagonal, found, last
//   apb      | in/out    | psel/penable  | paddr, pwdata, prdata
//
// A write request reads its row word, then modifies it and writes it back (ST_WR_RD, ST_WR_MOD).
// A query in the grid reads its three row words (ST_Q_UP to ST_Q_CAP), then gives one result
// per cycle unless rsp_o.ready stalls it. A clear request and the pass after reset zero the map,
// one row a cycle; no request is taken meanwhile, register writes still are.
// A new request is taken while the last result still waits; results stall on rsp_o.ready.
module grid_neighbour_generator
  import gng_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gng_req_if.sink           req_i,
  gng_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ROWS - 1);

  gng_state_e state_q, state_d;

  logic [6:0] rows_q, cols_q;
  logic       diag_q;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [5:0]    row_q, row_d, col_q, col_d;
  logic          bar_q, bar_d;
  logic [2:0]    up3_q, up3_d, mid3_q, mid3_d;
  logic [7:0]    mask_q, mask_d;

  logic       out_valid_q, out_valid_d;
  logic [5:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic       out_diag_q, out_diag_d, out_found_q, out_found_d, out_last_q, out_last_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  logic       req_fire, cfg_wr, out_free;
  logic [6:0] rows_eff, cols_eff, row_p1, col_p1, col_m1;
  logic       in_grid, has_up, has_dn, has_lf, has_rt;
  logic [2:0] rd3, sel;
  logic [7:0] mask_new, mask_rest;

  gng_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic cell_free(logic [MAX_COLS-1:0] word, logic [6:0] idx);
    logic ok;
    ok = 32'(idx) < MAX_COLS;
    return ok && !word[idx[CW-1:0]];
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      diag_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CFG_ROWS: rows_q <= pwdata[6:0];
        CFG_COLS: cols_q <= pwdata[6:0];
        CFG_DIAG: diag_q <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_ROWS: prdata = {25'd0, rows_q};
      CFG_COLS: prdata = {25'd0, cols_q};
      CFG_DIAG: prdata = {31'd0, diag_q};
      default:  prdata = 32'd0;
    endcase
  end

  // Grid bounds for the held cell.
  assign rows_eff = (rows_q == 7'd0) ? 7'd1 : rows_q;
  assign cols_eff = (cols_q == 7'd0) ? 7'd1 : cols_q;
  assign row_p1   = {1'b0, row_q} + 7'd1;
  assign col_p1   = {1'b0, col_q} + 7'd1;
  assign col_m1   = {1'b0, col_q} - 7'd1;
  assign has_up   = row_q != 6'd0;
  assign has_dn   = (row_p1 < rows_eff) && (32'(row_p1) < MAX_ROWS);
  assign has_lf   = col_q != 6'd0;
  assign has_rt   = (col_p1 < cols_eff) && (32'(col_p1) < MAX_COLS);
  assign in_grid  = ({1'b0, row_d} < rows_eff) && (32'(row_d) < MAX_ROWS)
                 && ({1'b0, col_d} < cols_eff) && (32'(col_d) < MAX_COLS);

  assign req_i.ready = state_q == ST_IDLE;
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Free bits at col-1, col and col+1 of the row word just read.
  assign rd3 = {has_rt && cell_free(ram_rdata, col_p1),
                cell_free(ram_rdata, {1'b0, col_q}),
                has_lf && cell_free(ram_rdata, col_m1)};

  always_comb begin
    mask_new        = 8'd0;
    mask_new[NB_UP] = up3_q[1];
    mask_new[NB_DN] = has_dn && rd3[1];
    mask_new[NB_LF] = mid3_q[0];
    mask_new[NB_RT] = mid3_q[2];
    mask_new[NB_UL] = diag_q && up3_q[0] && (up3_q[1] || mid3_q[0]);
    mask_new[NB_UR] = diag_q && up3_q[2] && (up3_q[1] || mid3_q[2]);
    mask_new[NB_DL] = diag_q && has_dn && rd3[0] && (rd3[1] || mid3_q[0]);
    mask_new[NB_DR] = diag_q && has_dn && rd3[2] && (rd3[1] || mid3_q[2]);
  end

  always_comb begin
    sel = NB_UP;
    for (int i = 7; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = 3'(i);
      end
    end
    mask_rest      = mask_q;
    mask_rest[sel] = 1'b0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (gng_func_e'(req_i.func))
            FUNC_WRITE: state_d = in_grid ? ST_WR_RD : ST_IDLE;
            FUNC_CLEAR: state_d = ST_CLEAR;
            FUNC_QUERY: state_d = in_grid ? ST_Q_UP : ST_EMPTY;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WR_RD:  state_d = ST_WR_MOD;
      ST_WR_MOD: state_d = ST_IDLE;
      ST_Q_UP:   state_d = ST_Q_MID;
      ST_Q_MID:  state_d = ST_Q_DN;
      ST_Q_DN:   state_d = ST_Q_CAP;
      ST_Q_CAP:  state_d = (mask_new == 8'd0) ? ST_EMPTY : ST_EMIT;
      ST_EMIT: begin
        if (out_free && mask_rest == 8'd0) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    bar_d       = bar_q;
    up3_d       = up3_q;
    mid3_d      = mid3_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_diag_d  = out_diag_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(row_q);
    ram_wdata   = ram_rdata;
    ram_raddr   = AW'(row_q);

    if (req_fire) begin
      row_d = req_i.cell_row;
      col_d = req_i.cell_col;
      bar_d = req_i.is_barrier;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = (clr_cnt_q == LAST_ROW) ? '0 : clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        clr_cnt_d = '0;
      end
      ST_WR_MOD: begin
        ram_we                 = 1'b1;
        ram_wdata[col_q[CW-1:0]] = bar_q;
      end
      ST_Q_UP: begin
        ram_raddr = has_up ? AW'(row_q - 6'd1) : AW'(row_q);
      end
      ST_Q_MID: begin
        up3_d = has_up ? rd3 : 3'd0;
      end
      ST_Q_DN: begin
        mid3_d    = rd3;
        ram_raddr = has_dn ? AW'(row_p1) : AW'(row_q);
      end
      ST_Q_CAP: begin
        mask_d = mask_new;
      end
      ST_EMIT: begin
        if (out_free) begin
          mask_d      = mask_rest;
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_last_d  = mask_rest == 8'd0;
          out_diag_d  = sel[2];
          case (sel)
            NB_UP, NB_UL, NB_UR: out_row_d = row_q - 6'd1;
            NB_DN, NB_DL, NB_DR: out_row_d = row_q + 6'd1;
            default:             out_row_d = row_q;
          endcase
          case (sel)
            NB_LF, NB_UL, NB_DL: out_col_d = col_q - 6'd1;
            NB_RT, NB_UR, NB_DR: out_col_d = col_q + 6'd1;
            default:             out_col_d = col_q;
          endcase
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_last_d  = 1'b1;
          out_diag_d  = 1'b0;
          out_row_d   = 6'd0;
          out_col_d   = 6'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    bar_q       <= bar_d;
    up3_q       <= up3_d;
    mid3_q      <= mid3_d;
    mask_q      <= mask_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_diag_q  <= out_diag_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.nbr_row     = out_row_q;
  assign rsp_o.nbr_col     = out_col_q;
  assign rsp_o.is_diagonal = out_diag_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.last        = out_last_q;

endmodule

>>> rtl/core/gng_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gng_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> tb/sv/grid_neighbour_generator_tb.sv
// Self-checking testbench for grid_neighbour_generator: it drives cell writes, clears and
// neighbour queries, and checks every neighbour result against its own copy of the grid.
// Depends on gng_pkg, gng_if and the grid_neighbour_generator RTL.
`timescale 1ns / 1ps

module grid_neighbour_generator_tb;
  import gng_pkg::*;

  localparam int unsigned GRID_ROWS = MAX_ROWS_DEF;
  localparam int unsigned GRID_COLS = MAX_COLS_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = GRID_ROWS + 16;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic       barrier;
  } cell_req_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic       diag;
    logic       found;
    logic       last;
  } nbr_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  gng_req_if req_if ();
  gng_rsp_if rsp_if ();

  grid_neighbour_generator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [GRID_COLS-1:0] barrier_cells [GRID_ROWS];
  logic [6:0] rows_reg;
  logic [6:0] cols_reg;
  logic diag_reg;
  nbr_t nbr_expect_q[$];
  int errors;
  int n_writes;
  int n_clears;
  int n_queries;
  int n_results;
  int quiet_cycles;
  bit steady;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int clamp_count(input logic [6:0] v, input int unsigned limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic bit is_free(input int r, input int c);
    return barrier_cells[r][c] == 1'b0;
  endfunction

  function automatic nbr_t make_nbr(input int r, input int c, input bit d);
    return {6'(r), 6'(c), d, 1'b1, 1'b0};
  endfunction

  function automatic cell_req_t make_req(input logic [1:0] f, input int r, input int c,
                                         input bit b);
    return {f, 6'(r), 6'(c), b};
  endfunction

  task automatic predict_request(input cell_req_t r);
    int nr, nc, row, col;
    bit has_up, has_dn, has_lf, has_rt;
    bit up_ok, dn_ok, lf_ok, rt_ok;
    nbr_t hits[$];
    nbr_t none;
    nr = clamp_count(rows_reg, GRID_ROWS);
    nc = clamp_count(cols_reg, GRID_COLS);
    row = r.row;
    col = r.col;
    up_ok = 1'b0;
    dn_ok = 1'b0;
    lf_ok = 1'b0;
    rt_ok = 1'b0;
    none = '0;
    case (r.func)
      FUNC_WRITE: begin
        n_writes++;
        if (row < nr && col < nc) barrier_cells[row][col] = r.barrier;
      end
      FUNC_CLEAR: begin
        n_clears++;
        foreach (barrier_cells[i]) barrier_cells[i] = '0;
      end
      FUNC_QUERY: begin
        n_queries++;
        if (row < nr && col < nc) begin
          has_up = row != 0;
          has_dn = row + 1 < nr;
          has_lf = col != 0;
          has_rt = col + 1 < nc;
          if (has_up && is_free(row - 1, col)) begin
            up_ok = 1'b1;
            hits.insert(hits.size(), make_nbr(row - 1, col, 1'b0));
          end
          if (has_dn && is_free(row + 1, col)) begin
            dn_ok = 1'b1;
            hits.insert(hits.size(), make_nbr(row + 1, col, 1'b0));
          end
          if (has_lf && is_free(row, col - 1)) begin
            lf_ok = 1'b1;
            hits.insert(hits.size(), make_nbr(row, col - 1, 1'b0));
          end
          if (has_rt && is_free(row, col + 1)) begin
            rt_ok = 1'b1;
            hits.insert(hits.size(), make_nbr(row, col + 1, 1'b0));
          end
          // A diagonal step needs at least one open orthogonal cell beside it.
          if (diag_reg) begin
            if (has_up && has_lf && (up_ok || lf_ok) && is_free(row - 1, col - 1))
              hits.insert(hits.size(), make_nbr(row - 1, col - 1, 1'b1));
            if (has_up && has_rt && (up_ok || rt_ok) && is_free(row - 1, col + 1))
              hits.insert(hits.size(), make_nbr(row - 1, col + 1, 1'b1));
            if (has_dn && has_lf && (dn_ok || lf_ok) && is_free(row + 1, col - 1))
              hits.insert(hits.size(), make_nbr(row + 1, col - 1, 1'b1));
            if (has_dn && has_rt && (dn_ok || rt_ok) && is_free(row + 1, col + 1))
              hits.insert(hits.size(), make_nbr(row + 1, col + 1, 1'b1));
          end
        end
        if (hits.size() == 0) hits.insert(0, none);
        hits[hits.size() - 1].last = 1'b1;
        foreach (hits[i]) nbr_expect_q.insert(nbr_expect_q.size(), hits[i]);
      end
      default: ;
    endcase
  endtask

  task automatic req_pause(input int n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic send_request(input cell_req_t r);
    if (!steady && $urandom_range(0, 3) == 0) req_pause($urandom_range(1, 8));
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.func <= r.func;
    req_if.cell_row <= r.row;
    req_if.cell_col <= r.col;
    req_if.is_barrier <= r.barrier;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_request(r);
  endtask

  task automatic query(input int r, input int c);
    send_request(make_req(FUNC_QUERY, r, c, 1'b0));
  endtask

  task automatic put_cell(input int r, input int c, input bit b);
    send_request(make_req(FUNC_WRITE, r, c, b));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (nbr_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [6:0] val);
    logic [31:0] readback;
    logic [31:0] want;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      CFG_ROWS: rows_reg = val;
      CFG_COLS: cols_reg = val;
      CFG_DIAG: diag_reg = val[0];
      default: ;
    endcase
    want = (idx == CFG_DIAG) ? {31'd0, val[0]} : {25'd0, val};
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    readback = prdata;
    if (readback !== want) begin
      errors++;
      $display("%0t: register %0d readback: expected 0x%08h, got 0x%08h",
               $time, idx, want, readback);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols, input bit diag);
    wait_idle();
    apb_write(CFG_ROWS, rows);
    apb_write(CFG_COLS, cols);
    apb_write(CFG_DIAG, {6'd0, diag});
  endtask

  task automatic test_default_grid();
    query(0, 0);
    query(63, 63);
    put_cell(63, 62, 1'b1);
    query(63, 63);
    send_request(make_req(FUNC_UNUSED, 63, 63, 1'b1));
    send_request(make_req(FUNC_CLEAR, 0, 0, 1'b0));
    query(63, 63);
    put_cell(0, 1, 1'b1);
    put_cell(0, 1, 1'b0);
    query(0, 0);
  endtask

  task automatic test_small_grid_diagonals();
    set_grid(7'd3, 7'd3, 1'b1);
    put_cell(3, 3, 1'b1);
    query(3, 1);
    query(1, 63);
    put_cell(0, 1, 1'b1);
    put_cell(1, 0, 1'b1);
    put_cell(1, 2, 1'b1);
    put_cell(2, 1, 1'b1);
    query(1, 1);
    put_cell(1, 0, 1'b0);
    query(1, 1);
    put_cell(1, 1, 1'b1);
    query(1, 1);
    query(0, 0);
  endtask

  task automatic test_clamped_sizes();
    set_grid(7'd0, 7'd127, 1'b1);
    query(0, 0);
    query(0, 63);
    put_cell(1, 5, 1'b1);
    set_grid(7'd1, 7'd1, 1'b0);
    query(0, 0);
    set_grid(7'd64, 7'd64, 1'b1);
    query(1, 1);
    query(63, 0);
  endtask

  task automatic random_items(input int count);
    int nr, nc, base_r, base_c, span_r, span_c, done, pick, row, col;
    cell_req_t r;
    nr = clamp_count(rows_reg, GRID_ROWS);
    nc = clamp_count(cols_reg, GRID_COLS);
    span_r = (nr > 6) ? 6 : nr;
    span_c = (nc > 6) ? 6 : nc;
    base_r = 0;
    base_c = 0;
    done = 0;
    while (done < count) begin
      // Keep traffic inside a small window so walls build up around the queried cells.
      if ($urandom_range(0, 15) == 0) begin
        base_r = $urandom_range(0, nr - span_r);
        base_c = $urandom_range(0, nc - span_c);
      end
      row = base_r + $urandom_range(0, span_r - 1);
      col = base_c + $urandom_range(0, span_c - 1);
      pick = $urandom_range(0, 99);
      if (pick < 6 && (nr < GRID_ROWS || nc < GRID_COLS)) begin
        if (nr < GRID_ROWS) row = $urandom_range(nr, 63);
        else col = $urandom_range(nc, 63);
        if ($urandom_range(0, 1) == 0) col = $urandom_range(0, 63);
        r = make_req($urandom_range(0, 1) ? FUNC_WRITE : FUNC_QUERY, row, col,
                     1'($urandom_range(0, 1)));
      end else if (pick < 8) begin
        r = make_req(FUNC_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
        r = make_req(FUNC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
      end else if (pick < 50) begin
        r = make_req(FUNC_WRITE, row, col, $urandom_range(0, 4) != 0);
      end else begin
        r = make_req(FUNC_QUERY, row, col, 1'($urandom_range(0, 1)));
      end
      send_request(r);
      if (r.func != FUNC_UNUSED) done++;
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] rows, cols;
    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: begin
          rows = 7'($urandom_range(2, 8));
          cols = 7'($urandom_range(2, 8));
        end
        1: begin
          rows = 7'($urandom_range(2, 8));
          cols = 7'($urandom_range(32, 64));
        end
        2: begin
          rows = 7'd64;
          cols = 7'd64;
        end
        default: begin
          rows = 7'($urandom_range(0, 127));
          cols = 7'($urandom_range(0, 127));
        end
      endcase
      set_grid(rows, cols, p % 3 != 1);
      random_items(55);
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    set_grid(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)), 1'b1);
    random_items(60);
    req_pause(1);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      if (!steady) begin
        repeat ($urandom_range(0, 7) == 0 ? 40 : $urandom_range(0, 12)) @(negedge clk_i);
        if (!steady) begin
          @(negedge clk_i);
          rsp_if.ready <= 1'b0;
          repeat ($urandom_range(0, 7)) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    nbr_t got;
    nbr_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = {rsp_if.nbr_row, rsp_if.nbr_col, rsp_if.is_diagonal, rsp_if.found, rsp_if.last};
      if (nbr_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d col %0d diag %0b found %0b last %0b",
                 $time, got.row, got.col, got.diag, got.found, got.last);
      end else begin
        want = nbr_expect_q.pop_front();
        n_results++;
        if (got.row !== want.row || got.col !== want.col || got.diag !== want.diag ||
            got.found !== want.found || got.last !== want.last) begin
          errors++;
          $display("%0t: expected row %0d col %0d diag %0b found %0b last %0b,",
                   $time, want.row, want.col, want.diag, want.found, want.last);
          $display("%0t: got row %0d col %0d diag %0b found %0b last %0b",
                   $time, got.row, got.col, got.diag, got.found, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
        (psel && penable && pready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("grid_neighbour_generator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_WRITE;
    req_if.cell_row = '0;
    req_if.cell_col = '0;
    req_if.is_barrier = 1'b0;
    rows_reg = ROWS_RST;
    cols_reg = COLS_RST;
    diag_reg = 1'b0;
    foreach (barrier_cells[i]) barrier_cells[i] = '0;
    errors = 0;
    n_writes = 0;
    n_clears = 0;
    n_queries = 0;
    n_results = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_grid();
    test_small_grid_diagonals();
    test_clamped_sizes();
    test_random_traffic();
    test_steady_stream();

    wait_idle();
    $display("Covered %0d cell writes, %0d clears and %0d queries on default, small,",
             n_writes, n_clears, n_queries);
    $display("clamped and full-size grids with and without diagonals; %0d results checked.",
             n_results);
    if (errors == 0) begin
      $display("grid_neighbour_generator regression: pass");
    end else begin
      $display("grid_neighbour_generator regression: fail");
    end
    $finish;
  end

endmodule
